[hdl/rcf_pkg.sv]
// rcf_pkg: shared types, constants and codes of the rgb convolution filter
// depends on nothing; used by the interfaces, controller, datapath and top level
package rcf_pkg;

	// default sizes
	localparam int KERNEL_SIZE_DEF = 3;
	localparam int MAX_HEIGHT_DEF  = 256;
	localparam int MAX_WIDTH_DEF   = 256;

	// fixed field widths
	localparam int COORD_W   = 8;
	localparam int CHAN_W    = 8;
	localparam int PIX_W     = 3 * CHAN_W;
	localparam int SIZE_W    = 9;
	localparam int FACTOR_W  = 16;
	localparam int BIAS_W    = 18;
	localparam int KROW_W    = 32;
	localparam int KROWS     = 4;
	localparam int COEF_W    = 8;
	localparam int KIDX_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// arithmetic widths: 16 taps of s8 * u8 fit in 20 bits
	localparam int ACC_W  = 20;
	localparam int PROD_W = ACC_W + FACTOR_W;
	localparam int VAL_W  = PROD_W + 1;

	// serial remainder unit, one dividend bit per step
	localparam int DIV_STEPS = COORD_W;
	localparam int DIV_CNT_W = 3;

	// request codes
	localparam logic REQ_WRITE   = 1'b0;
	localparam logic REQ_COMPUTE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KROW0  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_KROW1  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_KROW2  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_KROW3  = 3'd7;

	// reset values of the configuration registers
	localparam logic [SIZE_W-1:0]   HEIGHT_RST = 9'd256;
	localparam logic [SIZE_W-1:0]   WIDTH_RST  = 9'd256;
	localparam logic [FACTOR_W-1:0] FACTOR_RST = 16'd256;
	localparam logic [BIAS_W-1:0]   BIAS_RST   = 18'd0;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	// controller to datapath commands
	typedef struct packed {
		logic              load;
		logic              wr_en;
		logic              div_step;
		logic              issue;
		logic              col_step;
		logic              row_step;
		logic [KIDX_W-1:0] tap_a;
		logic [KIDX_W-1:0] tap_b;
		logic              mul_en;
		logic              fin_en;
	} rcf_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
	} rcf_sts_t;

endpackage

[hdl/rcf_if.sv]
// rcf_if: request, result and configuration channels of the rgb convolution filter
// depends on rcf_pkg for field widths
interface rcf_req_if;
	logic                             valid;
	logic                             ready;
	logic                             req_type;
	logic [rcf_pkg::COORD_W-1:0]      pixel_row;
	logic [rcf_pkg::COORD_W-1:0]      pixel_col;
	logic [rcf_pkg::CHAN_W-1:0]       in_red;
	logic [rcf_pkg::CHAN_W-1:0]       in_green;
	logic [rcf_pkg::CHAN_W-1:0]       in_blue;

	modport source (output valid, req_type, pixel_row, pixel_col, in_red, in_green, in_blue,
		input ready);
	modport sink (input valid, req_type, pixel_row, pixel_col, in_red, in_green, in_blue,
		output ready);
endinterface

interface rcf_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [rcf_pkg::CHAN_W-1:0]  out_red;
	logic [rcf_pkg::CHAN_W-1:0]  out_green;
	logic [rcf_pkg::CHAN_W-1:0]  out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface rcf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rcf_pkg::CFG_IDX_W-1:0]  index;
	logic [rcf_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/rcf_ram.sv]
// rcf_ram: generic single-port ram with registered read data
// depends on nothing
module rcf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one access per cycle, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/rcf_ctrl.sv]
// rcf_ctrl: controller state machine of the rgb convolution filter
// depends on rcf_pkg for command and status types
module rcf_ctrl #(
	parameter int KERNEL_SIZE = rcf_pkg::KERNEL_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_type,
	output logic              req_ready,
	input  rcf_pkg::rcf_sts_t sts,
	output rcf_pkg::rcf_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_READ  = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_MUL   = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	localparam logic [rcf_pkg::KIDX_W-1:0] TAP_LAST = rcf_pkg::KIDX_W'(KERNEL_SIZE - 1);
	localparam logic [rcf_pkg::DIV_CNT_W-1:0] DIV_LAST =
		rcf_pkg::DIV_CNT_W'(rcf_pkg::DIV_STEPS - 1);

	state_t                           st_q, st_d;
	logic [rcf_pkg::DIV_CNT_W-1:0]    div_cnt_q;
	logic [rcf_pkg::KIDX_W-1:0]       tap_a_q, tap_b_q;
	logic                             take;

	assign req_ready = (st_q == ST_IDLE);
	assign take      = req_valid && req_ready;

	// next state and commands
	always_comb begin
		st_d = st_q;
		cmd  = '0;
		cmd.tap_a = tap_a_q;
		cmd.tap_b = tap_b_q;
		unique case (st_q)
			ST_IDLE: begin
				if (take && req_type == rcf_pkg::REQ_WRITE) begin
					cmd.wr_en = 1'b1;
				end
				if (take && req_type == rcf_pkg::REQ_COMPUTE) begin
					cmd.load = 1'b1;
					st_d     = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					st_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.issue = 1'b1;
				if (tap_b_q == TAP_LAST) begin
					if (tap_a_q == TAP_LAST) begin
						st_d = ST_DRAIN;
					end else begin
						cmd.row_step = 1'b1;
					end
				end else begin
					cmd.col_step = 1'b1;
				end
			end
			ST_DRAIN: begin
				st_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				st_d       = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.fin_en = 1'b1;
					st_d       = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// step and tap counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			tap_a_q   <= '0;
			tap_b_q   <= '0;
		end else begin
			if (cmd.load) begin
				div_cnt_q <= '0;
				tap_a_q   <= '0;
				tap_b_q   <= '0;
			end else begin
				if (cmd.div_step) begin
					div_cnt_q <= div_cnt_q + 1'b1;
				end
				if (cmd.col_step) begin
					tap_b_q <= tap_b_q + 1'b1;
				end
				if (cmd.row_step) begin
					tap_a_q <= tap_a_q + 1'b1;
					tap_b_q <= '0;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	// an accepted compute starts the remainder steps
	a_compute_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE && req_valid && req_type == rcf_pkg::REQ_COMPUTE) |=> st_q == ST_DIV)
		else $error("compute transaction did not start division");

	// tap counters stay inside the kernel while reading
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_READ) |-> (tap_a_q <= TAP_LAST && tap_b_q <= TAP_LAST))
		else $error("kernel tap out of range");

	// a result waits while the output register is still occupied
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIN && !sts.out_free) |=> st_q == ST_FIN)
		else $error("result dropped while output busy");

	// division always ends with all dividend bits consumed
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV && st_d == ST_READ) |-> div_cnt_q == DIV_LAST)
		else $error("division left early");
`endif

endmodule

[hdl/rcf_dp.sv]
// rcf_dp: datapath of the rgb convolution filter: config registers, wrap
// remainders, frame address, multiply-accumulate, scaling and output register
// depends on rcf_pkg; drives the frame store ram
module rcf_dp #(
	parameter int KERNEL_SIZE = rcf_pkg::KERNEL_SIZE_DEF,
	parameter int MAX_HEIGHT  = rcf_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_WIDTH   = rcf_pkg::MAX_WIDTH_DEF,
	parameter int ADDR_W      = $clog2(MAX_HEIGHT * MAX_WIDTH)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes
	input  logic                            cfg_we,
	input  logic [rcf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rcf_pkg::CFG_DAT_W-1:0]   cfg_data,
	// request payload
	input  logic [rcf_pkg::COORD_W-1:0]     pixel_row,
	input  logic [rcf_pkg::COORD_W-1:0]     pixel_col,
	input  logic [rcf_pkg::CHAN_W-1:0]      in_red,
	input  logic [rcf_pkg::CHAN_W-1:0]      in_green,
	input  logic [rcf_pkg::CHAN_W-1:0]      in_blue,
	// controller link
	input  rcf_pkg::rcf_cmd_t               cmd,
	output rcf_pkg::rcf_sts_t               sts,
	// frame store
	output logic                            ram_we,
	output logic [ADDR_W-1:0]               ram_addr,
	output logic [rcf_pkg::PIX_W-1:0]       ram_wdata,
	input  logic [rcf_pkg::PIX_W-1:0]       ram_rdata,
	// result
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rcf_pkg::CHAN_W-1:0]      out_red,
	output logic [rcf_pkg::CHAN_W-1:0]      out_green,
	output logic [rcf_pkg::CHAN_W-1:0]      out_blue
);

	localparam int SW = rcf_pkg::SIZE_W;
	localparam int CW = rcf_pkg::COORD_W;

	logic [SW-1:0]                    height_q, width_q;
	logic signed [rcf_pkg::FACTOR_W-1:0] factor_q;
	logic signed [rcf_pkg::BIAS_W-1:0]   bias_q;
	logic [rcf_pkg::KROW_W-1:0]       krow_q [rcf_pkg::KROWS];

	logic [SW-1:0]  eff_h, eff_w;
	logic [CW-1:0]  row_sh_q, col_sh_q;
	logic [SW-1:0]  rem_r_q, rem_c_q, cbase_q;
	logic [SW:0]    trial_r, trial_c;
	logic [SW:0]    rem_r_nx, rem_c_nx;
	logic [SW:0]    r_inc, c_inc;

	logic           in_range;
	logic [ADDR_W-1:0] wr_addr, rd_addr;

	logic                           tap_vld_s1;
	logic [rcf_pkg::KIDX_W-1:0]     tap_a_s1, tap_b_s1;
	logic signed [rcf_pkg::COEF_W-1:0] coef;
	logic signed [rcf_pkg::ACC_W-1:0]  acc_q  [3];
	logic signed [rcf_pkg::PROD_W-1:0] prod_q [3];
	logic [rcf_pkg::CHAN_W-1:0]        res    [3];
	logic                              out_valid_q;
	logic [rcf_pkg::CHAN_W-1:0]        out_q  [3];

	// configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= rcf_pkg::HEIGHT_RST;
			width_q  <= rcf_pkg::WIDTH_RST;
			factor_q <= rcf_pkg::FACTOR_RST;
			bias_q   <= rcf_pkg::BIAS_RST;
			for (int i = 0; i < rcf_pkg::KROWS; i++) begin
				krow_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				rcf_pkg::CFG_HEIGHT: height_q <= cfg_data[SW-1:0];
				rcf_pkg::CFG_WIDTH:  width_q  <= cfg_data[SW-1:0];
				rcf_pkg::CFG_FACTOR: factor_q <= cfg_data[rcf_pkg::FACTOR_W-1:0];
				rcf_pkg::CFG_BIAS:   bias_q   <= cfg_data[rcf_pkg::BIAS_W-1:0];
				rcf_pkg::CFG_KROW0, rcf_pkg::CFG_KROW1,
				rcf_pkg::CFG_KROW2, rcf_pkg::CFG_KROW3: begin
					krow_q[cfg_index[rcf_pkg::KIDX_W-1:0]] <= cfg_data;
				end
				default: ;
			endcase
		end
	end

	// frame size in use: zero acts as one, clipped to the store
	always_comb begin
		if (height_q == '0) begin
			eff_h = SW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			eff_h = SW'(MAX_HEIGHT);
		end else begin
			eff_h = height_q;
		end
		if (width_q == '0) begin
			eff_w = SW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = SW'(MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
	end

	// restoring remainder step and wrapped increments
	always_comb begin
		trial_r  = {rem_r_q, row_sh_q[CW-1]};
		trial_c  = {rem_c_q, col_sh_q[CW-1]};
		rem_r_nx = (trial_r >= {1'b0, eff_h}) ? trial_r - {1'b0, eff_h} : trial_r;
		rem_c_nx = (trial_c >= {1'b0, eff_w}) ? trial_c - {1'b0, eff_w} : trial_c;
		r_inc    = {1'b0, rem_r_q} + 1'b1;
		c_inc    = {1'b0, rem_c_q} + 1'b1;
	end

	// row and column remainders, then the kernel walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_sh_q <= pixel_row;
			col_sh_q <= pixel_col;
			rem_r_q  <= '0;
			rem_c_q  <= '0;
		end else if (cmd.div_step) begin
			row_sh_q <= row_sh_q << 1;
			col_sh_q <= col_sh_q << 1;
			rem_r_q  <= rem_r_nx[SW-1:0];
			rem_c_q  <= rem_c_nx[SW-1:0];
			cbase_q  <= rem_c_nx[SW-1:0];
		end else if (cmd.row_step) begin
			rem_r_q <= (r_inc == {1'b0, eff_h}) ? '0 : r_inc[SW-1:0];
			rem_c_q <= cbase_q;
		end else if (cmd.col_step) begin
			rem_c_q <= (c_inc == {1'b0, eff_w}) ? '0 : c_inc[SW-1:0];
		end
	end

	// frame store port: writes from the request, reads from the walk
	always_comb begin
		in_range  = (32'(pixel_row) < MAX_HEIGHT) && (32'(pixel_col) < MAX_WIDTH);
		wr_addr   = ADDR_W'(pixel_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(pixel_col);
		rd_addr   = ADDR_W'(rem_r_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rem_c_q);
		ram_we    = cmd.wr_en && in_range;
		ram_addr  = cmd.issue ? rd_addr : wr_addr;
		ram_wdata = {in_red, in_green, in_blue};
	end

	// tap index follows the ram read latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_vld_s1 <= 1'b0;
		end else begin
			tap_vld_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		tap_a_s1 <= cmd.tap_a;
		tap_b_s1 <= cmd.tap_b;
	end

	assign coef = krow_q[tap_a_s1][rcf_pkg::COEF_W * tap_b_s1 +: rcf_pkg::COEF_W];

	// per channel multiply-accumulate, then scale
	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			if (cmd.load) begin
				acc_q[ch] <= '0;
			end else if (tap_vld_s1) begin
				acc_q[ch] <= acc_q[ch] + rcf_pkg::ACC_W'(coef) * rcf_pkg::ACC_W'($signed({1'b0,
					ram_rdata[rcf_pkg::PIX_W - 1 - rcf_pkg::CHAN_W * ch -: rcf_pkg::CHAN_W]}));
			end
			if (cmd.mul_en) begin
				prod_q[ch] <= rcf_pkg::PROD_W'(acc_q[ch]) * rcf_pkg::PROD_W'(factor_q);
			end
		end
	end

	// bias, floor and clamp
	always_comb begin
		logic signed [rcf_pkg::VAL_W-1:0] v;
		for (int ch = 0; ch < 3; ch++) begin
			v = rcf_pkg::VAL_W'(prod_q[ch]) + rcf_pkg::VAL_W'(bias_q);
			if (v[rcf_pkg::VAL_W-1]) begin
				res[ch] = '0;
			end else if (v[rcf_pkg::VAL_W-2:2*rcf_pkg::CHAN_W] != '0) begin
				res[ch] = rcf_pkg::CHAN_MAX;
			end else begin
				res[ch] = v[2*rcf_pkg::CHAN_W-1:rcf_pkg::CHAN_W];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_en) begin
			for (int ch = 0; ch < 3; ch++) begin
				out_q[ch] <= res[ch];
			end
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_red      = out_q[0];
	assign out_green    = out_q[1];
	assign out_blue     = out_q[2];

endmodule

[hdl/rgb_convolution_filter.sv]
// rgb_convolution_filter: frame store plus K by K rgb convolution with scale and bias.
// writes are taken back to back while idle; a compute runs 8 remainder steps for the
// wrap, one frame store read per tap through the single ram port, then drain, scale
// and clamp. one compute at a time; a result waits while the output register is busy.
// reset clears control and loads register defaults; the frame store is not cleared.
// depends on rcf_pkg, rcf_if, rcf_ram, rcf_ctrl and rcf_dp
module rgb_convolution_filter #(
	parameter int KERNEL_SIZE = rcf_pkg::KERNEL_SIZE_DEF,
	parameter int MAX_HEIGHT  = rcf_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_WIDTH   = rcf_pkg::MAX_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rcf_req_if.sink   req,
	rcf_rsp_if.source rsp,
	rcf_cfg_if.sink   cfg
);

	localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH;
	localparam int ADDR_W = $clog2(DEPTH);

	rcf_pkg::rcf_cmd_t            cmd;
	rcf_pkg::rcf_sts_t            sts;
	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_addr;
	logic [rcf_pkg::PIX_W-1:0]    ram_wdata, ram_rdata;
	logic                         req_ready;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;
	assign req.ready = req_ready;

	rcf_ctrl #(
		.KERNEL_SIZE(KERNEL_SIZE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rcf_dp #(
		.KERNEL_SIZE(KERNEL_SIZE),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WIDTH  (MAX_WIDTH),
		.ADDR_W     (ADDR_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.pixel_row (req.pixel_row),
		.pixel_col (req.pixel_col),
		.in_red    (req.in_red),
		.in_green  (req.in_green),
		.in_blue   (req.in_blue),
		.cmd       (cmd),
		.sts       (sts),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_red   (rsp.out_red),
		.out_green (rsp.out_green),
		.out_blue  (rsp.out_blue)
	);

	// frame store
	rcf_ram #(
		.WIDTH(rcf_pkg::PIX_W),
		.DEPTH(DEPTH)
	) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

[dv/rcf_check.sv]
// rcf_check: watches the request, result and configuration channels of the filter,
// keeps its own frame and registers, predicts every filtered pixel and compares
// depends on rcf_pkg and rcf_if
module rcf_check (
	input  logic        clk,
	input  logic        arst_n,
	rcf_req_if          req,
	rcf_rsp_if          rsp,
	rcf_cfg_if          cfg,
	output int unsigned pending,
	output int unsigned fails
);
	timeunit 1ns;
	timeprecision 1ps;
	import rcf_pkg::*;

	localparam int unsigned FRAME_DEPTH = MAX_HEIGHT_DEF * MAX_WIDTH_DEF;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	// shadow of the frame store and the register file
	logic [PIX_W-1:0]           frame [FRAME_DEPTH];
	logic [SIZE_W-1:0]          height_reg;
	logic [SIZE_W-1:0]          width_reg;
	logic signed [FACTOR_W-1:0] factor_reg;
	logic signed [BIAS_W-1:0]   bias_reg;
	logic [KROW_W-1:0]          krow [KROWS];

	rgb_t        filtered_q [$];
	int unsigned fail_cnt = 0;

	// frame size in use: zero acts as one, oversize acts as the store size
	function automatic int unsigned clip_size(logic [SIZE_W-1:0] v, int unsigned lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	// scale, add bias, floor and clamp one channel sum
	function automatic logic [CHAN_W-1:0] scale_clamp(longint sum);
		longint v;
		longint q;
		v = sum * longint'(factor_reg) + longint'(bias_reg);
		if (v < 0)
			return '0;
		q = v / 256;
		if (q > 255)
			return CHAN_MAX;
		return q[CHAN_W-1:0];
	endfunction

	// k by k convolution from (row, col) down and right, wrapping modulo the frame size
	function automatic rgb_t filter_pixel(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
		int unsigned h;
		int unsigned w;
		int unsigned r;
		int unsigned c;
		longint sum_r;
		longint sum_g;
		longint sum_b;
		logic signed [COEF_W-1:0] k;
		logic [PIX_W-1:0] px;
		rgb_t res;
		h = clip_size(height_reg, MAX_HEIGHT_DEF);
		w = clip_size(width_reg, MAX_WIDTH_DEF);
		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		for (int a = 0; a < KERNEL_SIZE_DEF; a++) begin
			r = (int'(row) + a) % h;
			for (int b = 0; b < KERNEL_SIZE_DEF; b++) begin
				c = (int'(col) + b) % w;
				px = frame[r * MAX_WIDTH_DEF + c];
				k = krow[a][COEF_W*b +: COEF_W];
				sum_r += longint'(k) * longint'(px[3*CHAN_W-1:2*CHAN_W]);
				sum_g += longint'(k) * longint'(px[2*CHAN_W-1:CHAN_W]);
				sum_b += longint'(k) * longint'(px[CHAN_W-1:0]);
			end
		end
		res.red = scale_clamp(sum_r);
		res.green = scale_clamp(sum_g);
		res.blue = scale_clamp(sum_b);
		return res;
	endfunction

	function automatic void compare_chan(string field, logic [CHAN_W-1:0] want,
		logic [CHAN_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			fail_cnt++;
		end
	endfunction

	always @(posedge clk) begin
		rgb_t want;
		if (!arst_n) begin
			height_reg = HEIGHT_RST;
			width_reg = WIDTH_RST;
			factor_reg = FACTOR_RST;
			bias_reg = BIAS_RST;
			for (int i = 0; i < KROWS; i++)
				krow[i] = '0;
			filtered_q.delete();
			pending <= 0;
			fails <= 0;
		end else begin
			// result transaction: compare with the oldest prediction
			if (rsp.valid && rsp.ready) begin
				if (filtered_q.size() == 0) begin
					$error("unexpected result: red %0d green %0d blue %0d",
						rsp.out_red, rsp.out_green, rsp.out_blue);
					fail_cnt++;
				end else begin
					want = filtered_q.pop_front();
					compare_chan("out_red", want.red, rsp.out_red);
					compare_chan("out_green", want.green, rsp.out_green);
					compare_chan("out_blue", want.blue, rsp.out_blue);
				end
			end

			// register write transaction
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				CFG_HEIGHT: height_reg = cfg.data[SIZE_W-1:0];
				CFG_WIDTH:  width_reg = cfg.data[SIZE_W-1:0];
				CFG_FACTOR: factor_reg = cfg.data[FACTOR_W-1:0];
				CFG_BIAS:   bias_reg = cfg.data[BIAS_W-1:0];
				CFG_KROW0:  krow[0] = cfg.data;
				CFG_KROW1:  krow[1] = cfg.data;
				CFG_KROW2:  krow[2] = cfg.data;
				CFG_KROW3:  krow[3] = cfg.data;
				default: ;
				endcase
			end

			// request transaction: store a pixel or predict a filtered one
			if (req.valid && req.ready) begin
				if (req.req_type == REQ_WRITE) begin
					frame[int'(req.pixel_row) * MAX_WIDTH_DEF + req.pixel_col] =
						{req.in_red, req.in_green, req.in_blue};
				end else begin
					filtered_q.push_back(filter_pixel(req.pixel_row, req.pixel_col));
				end
			end

			pending <= filtered_q.size();
			fails <= fail_cnt;
		end
	end

endmodule

[dv/testbench.sv]
// testbench: drives pixel writes, filter requests and register writes into the filter,
// stalls the result side at random and reports the verdict from rcf_check
// depends on rcf_pkg, rcf_if, rcf_check and rgb_convolution_filter
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rcf_pkg::*;

	localparam int unsigned ITEM_TARGET  = 1750;
	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned RESET_CYCLES = 11;
	localparam int unsigned NUM_REGS     = 8;
	localparam int unsigned SMALL_FRAME  = 64;
	localparam int unsigned PATCH_SPAN   = 5;
	localparam int unsigned FRAME_PIXELS = MAX_HEIGHT_DEF * MAX_WIDTH_DEF;

	typedef enum {KERN_SMOOTH, KERN_EDGE, KERN_WILD} kern_style_e;

	logic clk;
	logic arst_n;

	rcf_req_if req ();
	rcf_rsp_if rsp ();
	rcf_cfg_if cfg ();

	int unsigned pending;
	int unsigned fails;
	int unsigned cycles = 0;
	int unsigned items = 0;

	// pixels known to hold data, and the frame size in use
	bit          written [FRAME_PIXELS];
	int unsigned frame_h;
	int unsigned frame_w;
	int unsigned patch_r;
	int unsigned patch_c;

	logic [CFG_DAT_W-1:0] next_regs [NUM_REGS];

	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	rgb_convolution_filter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	rcf_check u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.cfg     (cfg),
		.pending (pending),
		.fails   (fails)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 80)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 15);
		return $urandom_range(30, 90);
	endfunction

	function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return SIZE_W'($urandom_range(1, 8));
		if (roll < 65)
			return '0;
		if (roll < 75)
			return SIZE_W'($urandom_range(257, 511));
		if (roll < 88)
			return SIZE_W'($urandom_range(9, 40));
		return SIZE_W'($urandom_range(200, 256));
	endfunction

	// every tap of a filter request at (row, col) reads a written pixel
	function automatic bit taps_written(int unsigned row, int unsigned col);
		for (int a = 0; a < KERNEL_SIZE_DEF; a++)
			for (int b = 0; b < KERNEL_SIZE_DEF; b++)
				if (!written[((row + a) % frame_h) * MAX_WIDTH_DEF + (col + b) % frame_w])
					return 1'b0;
		return 1'b1;
	endfunction

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int unsigned stall;
		stall = 0;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end else if (stall == 0 && !quiet && $urandom_range(0, 3) == 0) begin
				stall = pick_gap();
			end
			if (stall != 0) begin
				rsp.ready <= 1'b0;
				stall--;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// one request transaction, after an optional gap
	task automatic send_req(logic kind, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
		logic [PIX_W-1:0] rgb);
		int unsigned gap;
		gap = quiet ? 0 : pick_gap();
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.pixel_row <= row;
		req.pixel_col <= col;
		req.in_red <= rgb[3*CHAN_W-1:2*CHAN_W];
		req.in_green <= rgb[2*CHAN_W-1:CHAN_W];
		req.in_blue <= rgb[CHAN_W-1:0];
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		items++;
		if (kind == REQ_WRITE)
			written[{row, col}] = 1'b1;
	endtask

	task automatic write_pixel(int unsigned row, int unsigned col, logic [PIX_W-1:0] rgb);
		send_req(REQ_WRITE, COORD_W'(row), COORD_W'(col), rgb);
	endtask

	// color fields carry junk on a filter request
	task automatic filter_at(int unsigned row, int unsigned col);
		send_req(REQ_COMPUTE, COORD_W'(row), COORD_W'(col), PIX_W'($urandom()));
	endtask

	// filter request anywhere if safe, else inside the written patch, aliased upward
	task automatic filter_random();
		int unsigned row;
		int unsigned col;
		row = $urandom_range(0, 255);
		col = $urandom_range(0, 255);
		if (!taps_written(row, col)) begin
			row = (patch_r + $urandom_range(0, PATCH_SPAN - KERNEL_SIZE_DEF)) % frame_h;
			col = (patch_c + $urandom_range(0, PATCH_SPAN - KERNEL_SIZE_DEF)) % frame_w;
			row += frame_h * $urandom_range(0, (255 - row) / frame_h);
			col += frame_w * $urandom_range(0, (255 - col) / frame_w);
		end
		filter_at(row, col);
	endtask

	// drop valid, wait for every result, then let the block settle
	task automatic wait_idle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write transactions for the selected indexes, back to back
	task automatic load_regs(bit [NUM_REGS-1:0] sel);
		for (int i = CFG_HEIGHT; i <= CFG_KROW3; i++) begin
			if (sel[i]) begin
				cfg.valid <= 1'b1;
				cfg.index <= CFG_IDX_W'(i);
				cfg.data <= next_regs[i];
				@(posedge clk);
				while (!cfg.ready) @(posedge clk);
			end
		end
		cfg.valid <= 1'b0;
		if (sel[CFG_HEIGHT])
			frame_h = eff_size(next_regs[CFG_HEIGHT][SIZE_W-1:0], MAX_HEIGHT_DEF);
		if (sel[CFG_WIDTH])
			frame_w = eff_size(next_regs[CFG_WIDTH][SIZE_W-1:0], MAX_WIDTH_DEF);
	endtask

	// new settings with random junk above each register's width
	task automatic random_config(bit all_regs);
		kern_style_e style;
		int coef_lo;
		int coef_hi;
		int factor;
		int bias;
		logic [KROW_W-1:0] row_v;
		bit [NUM_REGS-1:0] sel;
		style = kern_style_e'($urandom_range(0, 2));
		case (style)
		KERN_SMOOTH: begin
			coef_lo = 0;
			coef_hi = 4;
			factor = $urandom_range(8, 40);
			bias = int'($urandom_range(0, 4096)) - 2048;
		end
		KERN_EDGE: begin
			coef_lo = -3;
			coef_hi = 3;
			factor = $urandom_range(32, 512);
			bias = 32768 + int'($urandom_range(0, 8192)) - 4096;
		end
		default: begin
			coef_lo = -128;
			coef_hi = 127;
			factor = $urandom_range(0, 65535);
			bias = $urandom_range(0, (1 << BIAS_W) - 1);
		end
		endcase
		next_regs[CFG_HEIGHT] = {23'($urandom()), pick_size()};
		next_regs[CFG_WIDTH] = {23'($urandom()), pick_size()};
		next_regs[CFG_FACTOR] = {16'($urandom()), 16'(factor)};
		next_regs[CFG_BIAS] = {14'($urandom()), 18'(bias)};
		for (int a = 0; a < KROWS; a++) begin
			row_v = $urandom();
			if (style != KERN_WILD)
				for (int b = 0; b < KROW_W / COEF_W; b++)
					row_v[COEF_W*b +: COEF_W] =
						COEF_W'(coef_lo + int'($urandom_range(0, coef_hi - coef_lo)));
			next_regs[CFG_KROW0 + a] = row_v;
		end
		for (int i = 0; i < NUM_REGS; i++)
			sel[i] = all_regs || $urandom_range(0, 3) != 0;
		load_regs(sel);
	endtask

	// small frames are written whole, large ones get a patch
	task automatic fill_frame();
		int unsigned r;
		int unsigned c;
		if (frame_h * frame_w <= SMALL_FRAME) begin
			for (int unsigned i = 0; i < frame_h; i++)
				for (int unsigned j = 0; j < frame_w; j++)
					if (!written[i * MAX_WIDTH_DEF + j])
						write_pixel(i, j, PIX_W'($urandom()));
		end else begin
			patch_r = $urandom_range(0, frame_h - 1);
			patch_c = $urandom_range(0, frame_w - 1);
			for (int unsigned i = 0; i < PATCH_SPAN; i++) begin
				for (int unsigned j = 0; j < PATCH_SPAN; j++) begin
					r = (patch_r + i) % frame_h;
					c = (patch_c + j) % frame_w;
					if (!written[r * MAX_WIDTH_DEF + c])
						write_pixel(r, c, PIX_W'($urandom()));
				end
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		int unsigned phase_cnt;
		int unsigned burst;
		logic [PIX_W-1:0] shade;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.req_type <= REQ_WRITE;
		req.pixel_row <= '0;
		req.pixel_col <= '0;
		req.in_red <= '0;
		req.in_green <= '0;
		req.in_blue <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= CFG_HEIGHT;
		cfg.data <= '0;
		frame_h = MAX_HEIGHT_DEF;
		frame_w = MAX_WIDTH_DEF;
		patch_r = MAX_HEIGHT_DEF - 1;
		patch_c = MAX_WIDTH_DEF - 1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3 patch across the corner of the store, extreme colors
		for (int i = 0; i < 9; i++) begin
			case (i % 3)
			0: shade = 24'hFFFFFF;
			1: shade = 24'h807F01;
			default: shade = 24'h000000;
			endcase
			write_pixel(8'(255 + i / 3), 8'(255 + i % 3), shade);
		end
		// reset settings: all-zero kernel gives black
		filter_at(255, 255);
		wait_idle();

		// two rows, zero width acts as one column, max positive kernel saturates
		next_regs[CFG_HEIGHT] = 32'hFFFF_FE02;
		next_regs[CFG_WIDTH] = 32'h0000_0000;
		next_regs[CFG_FACTOR] = 32'h0000_0100;
		next_regs[CFG_BIAS] = 32'h0000_0000;
		next_regs[CFG_KROW0] = 32'h7F7F_7F7F;
		next_regs[CFG_KROW1] = 32'h7F7F_7F7F;
		next_regs[CFG_KROW2] = 32'h7F7F_7F7F;
		next_regs[CFG_KROW3] = 32'h7F7F_7F7F;
		load_regs('1);
		filter_at(0, 0);
		filter_at(255, 255);
		filter_at(128, 77);
		wait_idle();

		// oversize frame acts as full store; most negative kernel goes below zero
		next_regs[CFG_HEIGHT] = 32'd511;
		next_regs[CFG_WIDTH] = 32'd300;
		next_regs[CFG_KROW0] = 32'h8080_8080;
		next_regs[CFG_KROW1] = 32'h8080_8080;
		next_regs[CFG_KROW2] = 32'h8080_8080;
		next_regs[CFG_KROW3] = 32'h8080_8080;
		load_regs('1);
		filter_at(255, 255);
		wait_idle();
		// most negative factor flips it to saturation
		next_regs[CFG_FACTOR] = 32'h0000_8000;
		load_regs(NUM_REGS'(1) << CFG_FACTOR);
		filter_at(255, 255);
		wait_idle();

		// mixed kernel, largest factor, most negative bias
		next_regs[CFG_FACTOR] = 32'h0000_7FFF;
		next_regs[CFG_BIAS] = 32'h0002_0000;
		next_regs[CFG_KROW0] = 32'h7F01_FF80;
		next_regs[CFG_KROW1] = 32'h80FF_017F;
		next_regs[CFG_KROW2] = 32'h0102_FEFD;
		load_regs('1);
		filter_at(255, 255);
		wait_idle();
		// zero kernel, largest bias
		next_regs[CFG_BIAS] = 32'h0001_FFFF;
		next_regs[CFG_KROW0] = 32'h0000_0000;
		next_regs[CFG_KROW1] = 32'h0000_0000;
		next_regs[CFG_KROW2] = 32'h0000_0000;
		load_regs('1);
		filter_at(255, 255);

		// random phases: new settings, frame fill, then mixed writes and filter requests
		phase_cnt = 0;
		while (items < ITEM_TARGET) begin
			wait_idle();
			random_config(phase_cnt == 0);
			quiet = ($urandom_range(0, 3) == 0);
			fill_frame();
			if (phase_cnt == 2)
				hold_req = 1'b1;
			burst = $urandom_range(30, 90);
			repeat (burst) begin
				if ($urandom_range(0, 99) < 35)
					write_pixel($urandom_range(0, 255), $urandom_range(0, 255),
						PIX_W'($urandom()));
				else
					filter_random();
			end
			phase_cnt++;
		end
		quiet = 1'b0;
		wait_idle();

		if (fails == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
hdl/rcf_pkg.sv
hdl/rcf_if.sv
hdl/rcf_ram.sv
hdl/rcf_ctrl.sv
hdl/rcf_dp.sv
hdl/rgb_convolution_filter.sv
dv/rcf_check.sv
dv/testbench.sv
